@@ rtl/lvps_pkg.sv @@
`default_nettype none

package lvps_pkg;

  // byte value that opens a run
  localparam logic [7:0] OPEN_BYTE = 8'd40;

  // width of the result length field
  localparam int unsigned LONGEST_W = 17;

  // how the second stage measures the run of a beat
  typedef enum logic [1:0] {
    RUN_NONE,
    RUN_BASE,
    RUN_TOP
  } run_kind_t;

endpackage

`default_nettype wire

@@ rtl/lvps_stack_ram.sv @@
`default_nettype none

module lvps_stack_ram
  import lvps_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/longest_valid_paren_stream.sv @@
`default_nettype none

// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_symbol[7:0], in_end_of_string
// out     | output    | out_valid / out_ready | out_longest[16:0], out_overflow
//
// one byte is taken every cycle while in_ready is high; the final byte passes
// the stage two register before the result register raises out_valid.
// stage one updates counters and pushes or reads the stack ram; stage two
// takes the registered ram read (new top) and updates the longest run.
// reset (synchronous, active low) clears counters and flags; the stack ram
// is not cleared, only entries below the stack count are ever read.
// in_ready drops only while a final beat waits behind a full output register.

module longest_valid_paren_stream
  import lvps_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned MAX_LEN     = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_symbol,
  input  wire logic                 in_end_of_string,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [LONGEST_W-1:0]      out_longest,
  output logic                      out_overflow
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam int unsigned SW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [PW-1:0] MAXLEN_C = PW'(MAX_LEN);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [CW-1:0] CNT_TWO = CW'(2);
  localparam logic [PW-1:0] POS_ONE = PW'(1);

  // stage one state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] base_r, base_nxt;
  logic          ovf_r, ovf_nxt;

  // stage two registers
  logic          s2_valid_r;
  logic          s2_last_r;
  logic          s2_ovf_r;
  run_kind_t     s2_kind_r;
  logic [SW-1:0] s2_here_r;
  logic [PW-1:0] s2_run_r;

  // longest run and output register
  logic [PW-1:0]        best_r;
  logic                 out_valid_r;
  logic [LONGEST_W-1:0] out_longest_r;
  logic                 out_ovf_r;

  // stack ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;

  logic          accept;
  logic          s2_blocked;
  logic          s2_fire;
  logic          is_open;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] cnt_dec2;
  run_kind_t     kind_nxt;
  logic [PW-1:0] run_nxt;
  logic          ovf_beat;

  logic [PW-1:0]           run_val;
  logic [PW-1:0]           cand;
  logic [PW+LONGEST_W-1:0] cand_ext;

  // flow control: stage two stalls only with a final beat and a full output
  assign s2_blocked = s2_valid_r && s2_last_r && out_valid_r && !out_ready;
  assign in_ready   = !s2_blocked;
  assign accept     = in_valid && in_ready;
  assign s2_fire    = s2_valid_r && !s2_blocked;

  assign is_open  = (in_symbol == OPEN_BYTE);
  assign cnt_dec  = cnt_r - CNT_ONE;
  assign cnt_dec2 = cnt_r - CNT_TWO;

  // stage one: counters, push and new top read
  always_comb begin
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    base_nxt  = base_r;
    ovf_beat  = ovf_r;
    kind_nxt  = RUN_NONE;
    run_nxt   = '0;
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = pos_r[SW-1:0];
    ram_re    = 1'b0;
    ram_raddr = cnt_dec2[AW-1:0];
    if (accept) begin
      if (pos_r >= MAXLEN_C) begin
        ovf_beat = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_ONE;
        if (is_open) begin
          if (cnt_r >= DEPTH_C) begin
            ovf_beat = 1'b1;
          end else begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_ONE;
          end
        end else if (cnt_r == '0) begin
          base_nxt = pos_r + POS_ONE;
        end else begin
          cnt_nxt = cnt_dec;
          if (cnt_r == CNT_ONE) begin
            kind_nxt = RUN_BASE;
            run_nxt  = pos_r + POS_ONE - base_r;
          end else begin
            kind_nxt = RUN_TOP;
            ram_re   = 1'b1;
          end
        end
      end
      // final byte clears the string state
      if (in_end_of_string) begin
        cnt_nxt  = '0;
        pos_nxt  = '0;
        base_nxt = '0;
      end
    end
    ovf_nxt = (accept && in_end_of_string) ? 1'b0 : ovf_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pos_r  <= '0;
      base_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pos_r  <= pos_nxt;
      base_r <= base_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // stage two pipeline register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!s2_blocked) begin
      s2_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_last_r <= in_end_of_string;
      s2_ovf_r  <= ovf_beat;
      s2_kind_r <= kind_nxt;
      s2_here_r <= pos_r[SW-1:0];
      s2_run_r  <= run_nxt;
    end
  end

  lvps_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (SW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // stage two: run length and longest run
  always_comb begin
    run_val = s2_run_r;
    if (s2_kind_r == RUN_TOP) begin
      run_val = PW'(s2_here_r - ram_rdata);
    end
    cand = best_r;
    if ((s2_kind_r != RUN_NONE) && (run_val > best_r)) begin
      cand = run_val;
    end
    cand_ext = {{LONGEST_W{1'b0}}, cand};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (s2_fire) begin
      best_r <= s2_last_r ? '0 : cand;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_last_r) begin
      out_longest_r <= cand_ext[LONGEST_W-1:0];
      out_ovf_r     <= s2_ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_longest  = out_longest_r;
  assign out_overflow = out_ovf_r;

`ifndef SYNTHESIS
  // a beat either pushes or reads the stack, never both
  a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("stack ram read and write in one cycle");

  // stack count stays within the ram
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("stack count beyond depth");

  // a new result comes only from a final beat in stage two
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r && s2_last_r))
    else $error("result without a final beat");
`endif

endmodule

`default_nettype wire

@@ dv/lvps_run_checker.sv @@
`timescale 1ns / 1ps

module lvps_run_checker
  import lvps_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned MAX_LEN     = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_symbol,
  input  logic                 in_end_of_string,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [LONGEST_W-1:0] out_longest,
  input  logic                 out_overflow,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [LONGEST_W-1:0] longest;
    logic                 overflow;
  } run_result_t;

  // results owed by the block, oldest first
  run_result_t expected_runs[$];

  // shadow of the string state
  int unsigned open_pos [STACK_DEPTH];
  int unsigned depth;
  int unsigned cursor;
  int unsigned run_base;
  int unsigned best_run;
  bit          overflow_seen;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic clear_string();
    depth         = 0;
    cursor        = 0;
    run_base      = 0;
    best_run      = 0;
    overflow_seen = 1'b0;
  endtask

  // one byte of the string: push an open, pop and measure on a close
  task automatic track_paren_byte(input logic [7:0] sym);
    int unsigned here;
    int unsigned run;
    here = cursor;
    if (here >= MAX_LEN) begin
      // past the length limit the byte is dropped
      overflow_seen = 1'b1;
    end else begin
      cursor = here + 1;
      if (sym == OPEN_BYTE) begin
        if (depth >= STACK_DEPTH) begin
          overflow_seen = 1'b1;
        end else begin
          open_pos[depth] = here;
          depth++;
        end
      end else if (depth == 0) begin
        // unmatched close starts a fresh run after itself
        run_base = here + 1;
      end else begin
        depth--;
        if (depth == 0) run = here + 1 - run_base;
        else run = here - open_pos[depth - 1];
        if (run > best_run) best_run = run;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_result();
    run_result_t want;
    if (expected_runs.size() == 0) begin
      report_mismatch($sformatf("unexpected result longest=%0d overflow=%0b",
                                out_longest, out_overflow));
    end else begin
      want = expected_runs.pop_front();
      if (out_longest !== want.longest)
        report_mismatch($sformatf("longest %0d, expected %0d", out_longest, want.longest));
      if (out_overflow !== want.overflow)
        report_mismatch($sformatf("overflow %0b, expected %0b", out_overflow,
                                  want.overflow));
    end
  endtask

  // watch both channels; results are checked before the new beat is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_string();
      expected_runs.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        track_paren_byte(in_symbol);
        if (in_end_of_string) begin
          expected_runs.push_back('{longest: best_run[LONGEST_W-1:0],
                                    overflow: overflow_seen});
          clear_string();
        end
      end
    end
    pending <= expected_runs.size();
  end

endmodule

@@ dv/tb_longest_valid_paren_stream.sv @@
`timescale 1ns / 1ps

module tb_longest_valid_paren_stream;
  import lvps_pkg::*;

  localparam int unsigned STACK_DEPTH  = 1024;
  localparam int unsigned MAX_LEN      = 65536;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          PHASE_BEATS  = 230;
  localparam logic [7:0]  CLOSE_BYTE   = 8'd41;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic [7:0]           in_symbol = 8'd0;
  logic                 in_end_of_string = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [LONGEST_W-1:0] out_longest;
  logic                 out_overflow;

  int         fail_count;
  int         pending;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         cycle_count = 0;
  bit         hold_go = 1'b0;
  logic [7:0] str_buf[$];

  longest_valid_paren_stream #(
    .STACK_DEPTH(STACK_DEPTH),
    .MAX_LEN    (MAX_LEN)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_symbol       (in_symbol),
    .in_end_of_string(in_end_of_string),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_longest     (out_longest),
    .out_overflow    (out_overflow)
  );

  lvps_run_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .MAX_LEN    (MAX_LEN)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_symbol       (in_symbol),
    .in_end_of_string(in_end_of_string),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_longest     (out_longest),
    .out_overflow    (out_overflow),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_longest_valid_paren_stream NOT OK");
      $finish;
    end
  end

  // result receiver: random stalls, or one long hold-off on request
  always begin
    @(posedge clk);
    if (hold_go) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_go = 1'b0;
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // drive the string in str_buf, one beat per byte, last byte marked
  task automatic send_string();
    foreach (str_buf[i]) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid         <= 1'b1;
      in_symbol        <= str_buf[i];
      in_end_of_string <= (i == str_buf.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    str_buf.delete();
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
    send_string();
  endtask

  // wait until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly ')' but any non-open byte closes
  function automatic logic [7:0] pick_closer();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) return CLOSE_BYTE;
    b = 8'($urandom_range(0, 255));
    if (b == OPEN_BYTE) b = CLOSE_BYTE;
    return b;
  endfunction

  task automatic build_random_string();
    int kind;
    int len;
    int lvl;
    str_buf.delete();
    kind = $urandom_range(0, 9);
    lvl  = 0;
    if (kind <= 4) begin
      // nearly balanced nesting with random shape
      if ($urandom_range(0, 3) == 0) str_buf.push_back(pick_closer());
      len = $urandom_range(2, 30);
      for (int i = 0; i < len; i++) begin
        if (lvl == 0 || $urandom_range(0, 1) == 1) begin
          str_buf.push_back(OPEN_BYTE);
          lvl++;
        end else begin
          str_buf.push_back(pick_closer());
          lvl--;
        end
      end
      while (lvl > 0 && $urandom_range(0, 4) != 0) begin
        str_buf.push_back(pick_closer());
        lvl--;
      end
    end else if (kind <= 6) begin
      // loose mix of opens and closes
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++)
        str_buf.push_back($urandom_range(0, 1) ? OPEN_BYTE : pick_closer());
    end else if (kind == 7) begin
      // raw noise bytes
      len = $urandom_range(1, 16);
      for (int i = 0; i < len; i++) str_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 8) begin
      // deep nest, back-to-back pops
      len = $urandom_range(20, 80);
      for (int i = 0; i < len; i++) str_buf.push_back(OPEN_BYTE);
      len = $urandom_range(len / 2, len + 2);
      for (int i = 0; i < len; i++) str_buf.push_back(pick_closer());
    end else begin
      str_buf.push_back($urandom_range(0, 1) ? OPEN_BYTE : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int beats);
    int sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < beats) begin
      build_random_string();
      sent += str_buf.size();
      send_string();
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings, no idling
    send_text("(");
    send_text(")");
    send_text("()");
    send_text("(()");
    send_text(")()())");
    send_text("()(())");
    send_text("())(())");
    send_text("((()))");
    send_text("(()())");
    send_text("(()(((");
    send_text("))((");
    // closers that differ from the open byte in few or all bits
    str_buf = '{OPEN_BYTE, 8'h00};
    send_string();
    str_buf = '{OPEN_BYTE, 8'hFF};
    send_string();
    str_buf = '{OPEN_BYTE, 8'd39, OPEN_BYTE, 8'hA8};
    send_string();
    str_buf = '{OPEN_BYTE, OPEN_BYTE, 8'hD7, 8'h29, 8'h08};
    send_string();
    drain();

    run_phase(0, 0, PHASE_BEATS);

    // long receiver hold-off while short strings keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b1;
    for (int n = 0; n < 40; n++) begin
      str_buf.delete();
      str_buf.push_back($urandom_range(0, 1) ? OPEN_BYTE : pick_closer());
      if ($urandom_range(0, 1) == 1) str_buf.push_back(pick_closer());
      send_string();
    end
    drain();

    run_phase(66, 0, PHASE_BEATS);
    run_phase(0, 66, PHASE_BEATS);
    run_phase(34, 34, PHASE_BEATS);

    if (fail_count == 0) begin
      $display("tb_longest_valid_paren_stream OK");
    end else begin
      $display("tb_longest_valid_paren_stream NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lvps_pkg.sv
rtl/lvps_stack_ram.sv
rtl/longest_valid_paren_stream.sv
dv/lvps_run_checker.sv
dv/tb_longest_valid_paren_stream.sv
